>>> hw/rtl/hash_key_aggregator_assert.svh
// Assertion macros used by the checker file.
`ifndef HASH_KEY_AGGREGATOR_ASSERT_SVH
`define HASH_KEY_AGGREGATOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define HKA_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Implication whose consequence is checked on the next clock edge.
`define HKA_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

>>> hw/rtl/hka_pkg.sv
// ----------------------------------------------------------------------------
// hka_pkg
// Types and constants shared by the hash key aggregator modules.
// ----------------------------------------------------------------------------
package hka_pkg;
   localparam logic [63:0] KEY_MIXER = 64'h9E3779B185EBCA87;

   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_MERGED   = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_MAXED    = 3'd3;
   localparam logic [2:0] ST_READ     = 3'd4;

   localparam int KIND_RECORD = 0;

   // One classified word passed from the front part to the back part.
   typedef struct packed {
      logic        is_read;
      logic [47:0] key;
      logic [63:0] mask;
      logic        unbound;
      logic        activity;
      logic [15:0] pid;
      logic [15:0] slot;
      logic [31:0] mix_lo;
      logic [31:0] mix_hi_part;
   } job_type;
endpackage

>>> hw/rtl/hka_ram.sv
// ----------------------------------------------------------------------------
// hka_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hka_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

>>> hw/rtl/hka_front.sv
// ----------------------------------------------------------------------------
// hka_front
// Accepts words, computes the home slot and pushes jobs into a short queue.
// ----------------------------------------------------------------------------
module hka_front #(
   parameter int TABLE_SLOTS = 1024,
   parameter int MASK_BITS   = 64,
   parameter int PID_BITS    = 16,
   parameter int QDEPTH      = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_stall,
   input  logic             kind,
   input  logic [15:0]      group_index,
   input  logic [31:0]      name_key,
   input  logic [63:0]      set_mask,
   input  logic             set_unbound,
   input  logic             from_activity,
   input  logic [15:0]      package_id,
   input  logic [9:0]       slot_index,
   output logic             q_valid,
   input  logic             q_pop,
   output hka_pkg::job_type q_job
);
   import hka_pkg::*;

   localparam int SW = $clog2(TABLE_SLOTS);
   localparam int QW = $clog2(QDEPTH);

   // Stage 1: register the word with partial products of the mix.
   logic    s1_valid_ff;
   job_type s1_ff, s1_in;
   logic [63:0] prod_lo, prod_hi;
   logic [47:0] key;
   logic [63:0] mask_keep;

   // Queue.
   job_type q_ff [QDEPTH];
   logic [QW-1:0] wp_ff, rp_ff;
   logic [QW:0]   cnt_ff;
   logic          s1_adv;
   logic [SW-1:0] home;
   logic [31:0]   hi_sum;
   job_type       push_job;

   assign key       = {group_index, name_key};
   assign mask_keep = (MASK_BITS >= 64) ? '1 : ((64'd1 << MASK_BITS) - 64'd1);
   // key*C mod 2^64 = lo32(k)*C + (k_hi16*C_lo32 << 32), split to 32x32 pieces.
   assign prod_lo   = {32'd0, name_key} * {32'd0, KEY_MIXER[31:0]};
   assign prod_hi   = {32'd0, name_key} * {32'd0, KEY_MIXER[63:32]};

   always_comb begin
      s1_in.is_read     = kind;
      s1_in.key         = key;
      s1_in.mask        = set_mask & mask_keep;
      s1_in.unbound     = set_unbound;
      s1_in.activity    = from_activity;
      s1_in.pid         = package_id & 16'((32'd1 << PID_BITS) - 32'd1);
      s1_in.slot        = 16'(slot_index);
      s1_in.mix_lo      = prod_lo[31:0];
      s1_in.mix_hi_part = prod_lo[63:32] + prod_hi[31:0]
                        + 32'({16'd0, group_index} * KEY_MIXER[31:0]);
   end

   assign s1_adv   = s1_valid_ff && (cnt_ff < (QW+1)'(QDEPTH));
   assign in_stall = s1_valid_ff && !s1_adv;

   assign hi_sum = s1_ff.mix_hi_part;
   always_comb begin
      logic [63:0] full;
      full = {hi_sum, s1_ff.mix_lo};
      home = full[SW-1:0];
      push_job = s1_ff;
      if (!s1_ff.is_read) begin
         push_job.slot = 16'(home);
      end else begin
         push_job.slot = 16'(s1_ff.slot[SW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (in_valid && !in_stall) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            wp_ff <= (wp_ff == QW'(QDEPTH-1)) ? '0 : wp_ff + 1'b1;
         end
         if (q_pop) begin
            rp_ff <= (rp_ff == QW'(QDEPTH-1)) ? '0 : rp_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + (QW+1)'(s1_adv) - (QW+1)'(q_pop);
      end
      if (in_valid && !in_stall) begin
         s1_ff <= s1_in;
      end
      if (s1_adv) begin
         q_ff[wp_ff] <= push_job;
      end
   end

   assign q_valid = (cnt_ff != '0);
   assign q_job   = q_ff[rp_ff];
endmodule

>>> hw/rtl/hka_back.sv
// ----------------------------------------------------------------------------
// hka_back
// Probes the table one slot per read and performs insert, merge or read.
// ----------------------------------------------------------------------------
module hka_back #(
   parameter int TABLE_SLOTS   = 1024,
   parameter int ENTRY_LIMIT   = 1024,
   parameter int PACKAGE_SLOTS = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   output logic             q_pop,
   input  hka_pkg::job_type q_job,
   output logic             out_valid,
   input  logic             out_stall,
   output logic [2:0]       status,
   output logic             slot_used,
   output logic [15:0]      entry_group,
   output logic [31:0]      entry_key,
   output logic [31:0]      point_total,
   output logic [63:0]      entry_mask,
   output logic             entry_unbound,
   output logic             in_map_package,
   output logic [2:0]       package_total,
   output logic             package_overflow,
   output logic [63:0]      package_list,
   output logic [10:0]      entry_count
);
   import hka_pkg::*;

   localparam int SW = $clog2(TABLE_SLOTS);
   localparam int PW = $clog2(TABLE_SLOTS + 1);
   // Entry word: key 48, points 32, mask 64, flags 6, packages 64.
   localparam int DW = 48 + 32 + 64 + 6 + 64;
   // The memory word adds the slot valid bit on top.
   localparam int RW = DW + 1;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_ADDR, S_WAIT, S_CHECK
   } state_type;

   state_type   state_ff;
   job_type     job_ff;
   logic [SW-1:0] slot_ff;
   logic [PW-1:0] probes_ff;
   logic [PW-1:0] occ_ff;

   logic          wr_en;
   logic [DW-1:0] wr_data, rd_data;
   logic [RW-1:0] ram_wr_data, ram_rd_data;
   logic          r_valid;

   logic [47:0] r_key;
   logic [31:0] r_pts;
   logic [63:0] r_mask;
   logic [5:0]  r_flags;
   logic [63:0] r_pk;

   // Result register.
   logic        ov_ff;
   logic [2:0]  st_ff;
   logic [DW-1:0] od_ff;
   logic        oused_ff;
   logic [10:0] cnt_ff;

   assign r_valid = ram_rd_data[DW];
   assign rd_data = ram_rd_data[DW-1:0];
   assign {r_key, r_pts, r_mask, r_flags, r_pk} = rd_data;

   hka_ram #(.WIDTH(RW), .DEPTH(TABLE_SLOTS)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(slot_ff),
      .wr_data(ram_wr_data),
      .rd_addr(slot_ff),
      .rd_data(ram_rd_data)
   );

   // Package list update on the entry read (or a blank one for insert).
   logic [5:0]  nf;
   logic [63:0] npk;
   logic        hit;
   logic [2:0]  n;
   logic [47:0] wkey;
   logic [31:0] wpts;
   logic [63:0] wmask;
   logic        is_new;
   always_comb begin
      logic [5:0]  f0;
      logic [63:0] p0;
      f0 = is_new ? {5'd0, job_ff.unbound} : (r_flags | {5'd0, job_ff.unbound});
      p0 = is_new ? 64'd0 : r_pk;
      n  = f0[4:2];
      hit = 1'b0;
      for (int k = 0; k < 4; k++) begin
         if (k < int'(n) && p0[16*k +: 16] == job_ff.pid) hit = 1'b1;
      end
      nf  = f0;
      npk = p0;
      if (!job_ff.activity) begin
         nf[1] = 1'b1;
      end else if (!hit) begin
         if (int'(n) >= PACKAGE_SLOTS || n >= 3'd4) begin
            nf[5] = 1'b1;
         end else begin
            npk = p0 | ({48'd0, job_ff.pid} << (16 * n));
            nf[4:2] = n + 3'd1;
         end
      end
      wkey  = job_ff.key;
      wpts  = is_new ? 32'd1 : r_pts + 32'd1;
      wmask = is_new ? job_ff.mask : (r_mask | job_ff.mask);
      wr_data = {wkey, wpts, wmask, nf, npk};
   end

   logic slot_v;
   logic at_limit;
   logic key_hit;
   logic last_probe;
   logic done;
   logic fin_ok;
   logic fin;
   assign slot_v     = r_valid;
   assign at_limit   = (32'(occ_ff) >= 32'(ENTRY_LIMIT));
   assign is_new     = !slot_v;
   assign key_hit    = slot_v && (r_key == job_ff.key);
   assign last_probe = (32'(probes_ff) + 32'd1 >= 32'(TABLE_SLOTS));
   assign done       = job_ff.is_read || !slot_v || key_hit || last_probe;
   // A finished job only leaves once the result register is free.
   assign fin_ok     = !ov_ff || !out_stall;
   assign fin        = (state_ff == S_CHECK) && done && fin_ok;
   assign wr_en      = (state_ff == S_CLEAR)
                     || (fin && !job_ff.is_read
                         && ((!slot_v && !at_limit)
                             || (key_hit && r_pts != 32'hFFFFFFFF)));
   assign ram_wr_data = (state_ff == S_CLEAR) ? '0 : {1'b1, wr_data};

   assign q_pop = (state_ff == S_IDLE) && q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         slot_ff  <= '0;
         occ_ff   <= '0;
         ov_ff    <= 1'b0;
      end else begin
         ov_ff <= fin || (ov_ff && out_stall);
         case (state_ff)
            S_CLEAR: begin
               if (32'(slot_ff) == TABLE_SLOTS - 1) begin
                  slot_ff  <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  slot_ff <= slot_ff + 1'b1;
               end
            end
            S_IDLE: begin
               if (q_valid) begin
                  job_ff    <= q_job;
                  slot_ff   <= q_job.slot[SW-1:0];
                  probes_ff <= '0;
                  state_ff  <= S_ADDR;
               end
            end
            S_ADDR: state_ff <= S_WAIT;
            S_WAIT: state_ff <= S_CHECK;
            S_CHECK: begin
               if (!done) begin
                  probes_ff <= probes_ff + 1'b1;
                  slot_ff   <= (32'(slot_ff) == TABLE_SLOTS - 1) ? '0 : slot_ff + 1'b1;
                  state_ff  <= S_WAIT;
               end else if (fin_ok) begin
                  state_ff <= S_IDLE;
                  od_ff    <= (job_ff.is_read && slot_v) ? rd_data : '0;
                  oused_ff <= job_ff.is_read && slot_v;
                  cnt_ff   <= 11'(occ_ff + PW'(wr_en && is_new));
                  if (job_ff.is_read) begin
                     st_ff <= ST_READ;
                  end else if (!slot_v) begin
                     if (at_limit) begin
                        st_ff <= ST_FULL;
                     end else begin
                        st_ff  <= ST_INSERTED;
                        occ_ff <= occ_ff + 1'b1;
                     end
                  end else if (key_hit) begin
                     st_ff <= (r_pts == 32'hFFFFFFFF) ? ST_MAXED : ST_MERGED;
                  end else begin
                     st_ff <= ST_FULL;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Read-first RAM: the read in S_WAIT returns data for slot_ff.
   assign out_valid = ov_ff;
   assign status    = st_ff;
   assign slot_used = oused_ff;
   assign entry_group      = od_ff[DW-1 -: 16];
   assign entry_key        = od_ff[DW-17 -: 32];
   assign point_total      = od_ff[DW-49 -: 32];
   assign entry_mask       = od_ff[DW-81 -: 64];
   assign entry_unbound    = od_ff[64];
   assign in_map_package   = od_ff[65];
   assign package_total    = od_ff[68:66];
   assign package_overflow = od_ff[69];
   assign package_list     = od_ff[63:0];
   // Count snapshot is stable while the word waits.
   assign entry_count = cnt_ff;
endmodule

>>> hw/rtl/hash_key_aggregator.sv
// ----------------------------------------------------------------------------
// hash_key_aggregator
// Linear-probing hash table that aggregates points by group and name key.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake
// req_    | in        | req_valid / req_stall
// rsp_    | out       | rsp_valid / rsp_stall
//
// A word passes the front part's mix register and then its queue. The back
// part takes a word through the states pop, address, read and check when the
// first slot decides it, and through read and check again for every further
// slot probed, since each probe is one registered read of the table memory.
// After reset the back part clears the table, one slot per cycle, before it
// takes its first job. A stalled result holds the back part; the queue lets
// the front part keep taking words until it is full.
module hash_key_aggregator #(
   parameter int TABLE_SLOTS     = 1024,
   parameter int ENTRY_LIMIT     = 1024,
   parameter int MASK_BITS       = 64,
   parameter int PACKAGE_SLOTS   = 4,
   parameter int PACKAGE_ID_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [15:0] req_group_index,
   input  logic [31:0] req_name_key,
   input  logic [63:0] req_set_mask,
   input  logic        req_set_unbound,
   input  logic        req_from_activity,
   input  logic [15:0] req_package_id,
   input  logic [9:0]  req_slot_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic        rsp_slot_used,
   output logic [15:0] rsp_entry_group,
   output logic [31:0] rsp_entry_key,
   output logic [31:0] rsp_point_total,
   output logic [63:0] rsp_entry_mask,
   output logic        rsp_entry_unbound,
   output logic        rsp_in_map_package,
   output logic [2:0]  rsp_package_total,
   output logic        rsp_package_overflow,
   output logic [63:0] rsp_package_list,
   output logic [10:0] rsp_entry_count
);
   import hka_pkg::*;

   logic    q_valid, q_pop;
   job_type q_job;

   // The front part mixes the key and queues classified jobs.
   hka_front #(
      .TABLE_SLOTS(TABLE_SLOTS), .MASK_BITS(MASK_BITS),
      .PID_BITS(PACKAGE_ID_BITS), .QDEPTH(2)
   ) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_stall(req_stall),
      .kind(req_kind), .group_index(req_group_index), .name_key(req_name_key),
      .set_mask(req_set_mask), .set_unbound(req_set_unbound),
      .from_activity(req_from_activity), .package_id(req_package_id),
      .slot_index(req_slot_index),
      .q_valid(q_valid), .q_pop(q_pop), .q_job(q_job)
   );

   // The back part walks the probe sequence and owns the table.
   hka_back #(
      .TABLE_SLOTS(TABLE_SLOTS), .ENTRY_LIMIT(ENTRY_LIMIT),
      .PACKAGE_SLOTS(PACKAGE_SLOTS)
   ) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_pop(q_pop), .q_job(q_job),
      .out_valid(rsp_valid), .out_stall(rsp_stall),
      .status(rsp_status), .slot_used(rsp_slot_used),
      .entry_group(rsp_entry_group), .entry_key(rsp_entry_key),
      .point_total(rsp_point_total), .entry_mask(rsp_entry_mask),
      .entry_unbound(rsp_entry_unbound), .in_map_package(rsp_in_map_package),
      .package_total(rsp_package_total), .package_overflow(rsp_package_overflow),
      .package_list(rsp_package_list), .entry_count(rsp_entry_count)
   );
endmodule

>>> hw/rtl/hka_checker.sv
// ----------------------------------------------------------------------------
// hka_checker
// Port-level checks on the hash key aggregator, bound to the top level.
// ----------------------------------------------------------------------------
`include "hash_key_aggregator_assert.svh"
module hka_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic        rsp_slot_used,
   input logic [10:0] rsp_entry_count
);
   import hka_pkg::*;

   `HKA_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `HKA_ASSERT_IMPL(a_code, clock, reset, rsp_valid, rsp_status <= ST_READ)
   `HKA_ASSERT_IMPL(a_used, clock, reset, rsp_valid && rsp_slot_used,
      rsp_status == ST_READ)
   `HKA_ASSERT_IMPL(a_ins, clock, reset, rsp_valid && rsp_status == ST_INSERTED,
      rsp_entry_count != 11'd0)
endmodule

bind hash_key_aggregator hka_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_status(rsp_status), .rsp_slot_used(rsp_slot_used),
   .rsp_entry_count(rsp_entry_count)
);
